@@ sv/cebr_pkg.sv @@
// Package for the chain end bond rotation block: fixed-point constants,
// field widths, request codes and the CORDIC arctangent table. No dependencies.
package cebr_pkg;

	localparam int MAX_BEADS = 512;
	localparam int LEN_W = 10;
	localparam logic [LEN_W-1:0] CHAIN_LEN_RESET = 10'd2;

	localparam int COORD_W = 32;
	localparam int RAND_W = 18;
	localparam int ANGLE_W = 19;
	localparam int IDX_W = 9;

	// Request commands carried on s_tuser.
	typedef enum logic {CMD_WRITE = 1'b0, CMD_ROTATE = 1'b1} cmd_t;

	// Q16 constants: one, CORDIC start value (inverse gain), pi and pi/2.
	localparam int ONE_Q16 = 65536;
	localparam int CORDIC_X0 = 39797;
	localparam int PI_Q16 = 205887;
	localparam int HALF_PI_Q16 = 102944;
	localparam int CORDIC_STEPS = 16;

	// Arctangent of 2^-i in Q16 for CORDIC step i.
	function automatic logic [16:0] atan_q16(input logic [3:0] i);
		logic [16:0] v;
		begin
			case (i)
				4'd0: v = 17'd51472;
				4'd1: v = 17'd30386;
				4'd2: v = 17'd16055;
				4'd3: v = 17'd8150;
				4'd4: v = 17'd4091;
				4'd5: v = 17'd2047;
				4'd6: v = 17'd1024;
				4'd7: v = 17'd512;
				4'd8: v = 17'd256;
				4'd9: v = 17'd128;
				4'd10: v = 17'd64;
				4'd11: v = 17'd32;
				4'd12: v = 17'd16;
				4'd13: v = 17'd8;
				4'd14: v = 17'd4;
				4'd15: v = 17'd2;
				default: v = 17'd0;
			endcase
			return v;
		end
	endfunction

endpackage

@@ sv/cebr_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the bead position store. No dependencies.
module cebr_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/chain_end_bond_rotation.sv @@
// Chain end bond rotation: a write request goes to the bead store as it is
// accepted. A rotate request runs 37 operations on the shared 28x22 multiplier
// and a square root before its result is registered.
// The next request is taken the cycle after the result is registered.
// Asynchronous active-low reset clears control state and sets chain_length
// to 2; the bead store is not cleared and holds nothing useful until written.
module chain_end_bond_rotation #(
	parameter int MAX_BEADS = cebr_pkg::MAX_BEADS
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration: chain_length.
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [9:0]   cfg_data,
	// Requests. s_tdata from bit 0: bead_index, coord_x, coord_y, coord_z,
	// which_end, rand_a, rand_b, angle, zero padding.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [167:0] s_tdata,
	input  logic         s_tuser,   // command
	// Results. m_tdata from bit 0: end_index, new_x, new_y, new_z, padding.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,
	output logic         m_tuser    // root_clamped
);

	localparam int AW = $clog2(MAX_BEADS);
	localparam int NW = ($clog2(MAX_BEADS + 1) > cebr_pkg::LEN_W) ?
		$clog2(MAX_BEADS + 1) : cebr_pkg::LEN_W;
	localparam int CW = cebr_pkg::COORD_W;

	// The sequencer walks through address reads, the square root, and the
	// list of multiplier operations below. Each operation multiplies into p_q
	// in ST_MUL and writes the product back in ST_WB.
	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_E, ST_RD_NB, ST_CAP_NB, ST_MUL, ST_WB,
		ST_SQINIT, ST_SQRT, ST_ROW, ST_STORE
	} state_t;

	// Multiplier operations in program order. OP_MB is the rotation of the
	// bond by the matrix, repeated over rows, columns and two bond halves.
	typedef enum logic [4:0] {
		OP_AA, OP_BB, OP_AR, OP_BR,
		OP_PXPX, OP_PXPY, OP_PXPZ, OP_PYPY, OP_PYPZ, OP_PZPZ,
		OP_PZSP, OP_PYSP, OP_PXSP,
		OP_Q0, OP_Q1, OP_Q2, OP_Q3, OP_Q4, OP_Q5,
		OP_MB
	} op_t;

	state_t st_q;
	op_t op_q;

	logic [9:0] chain_len_q;

	// Request fields.
	logic              cmd_w;
	logic [8:0]        bead_idx_w;
	logic [CW-1:0]     cx_w, cy_w, cz_w;
	logic              which_w;
	logic signed [17:0] ra_w, rb_w;
	logic signed [18:0] ang_w;
	logic              s_acc;

	// Captured operands and addresses.
	logic signed [17:0] a_q, b_q;
	logic [AW-1:0]     e_addr_q, nb_addr_q;

	// Chain ends.
	logic [NW-1:0] len_ext, n_w;
	logic [AW-1:0] e_addr_w, nb_addr_w;

	// Bead data.
	logic [3*CW-1:0]    ram_rdata, ram_wdata;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic               ram_we;
	logic signed [CW-1:0] e_pos_q [3];
	logic signed [CW-1:0] nb_q [3];
	logic signed [32:0] bond_q [3];

	// Axis, square root and trig values.
	logic [35:0]        s2_q;
	logic               clamp_q;
	logic [33:0]        rem_q, res_q, bit_q, trial_w;
	logic signed [19:0] px_q, py_q;
	logic signed [21:0] pz_q;
	logic signed [19:0] cor_x_q, cor_y_q, cor_z_q;
	logic [3:0]         cor_cnt_q;
	logic               cor_run_q, cor_neg_q;
	logic signed [19:0] cp_w, sp_w;
	logic signed [20:0] omc_w;
	logic signed [19:0] ang_ext, ang_red;
	logic               ang_neg;

	// Products and matrix.
	logic signed [25:0] pp_q [6];
	logic signed [21:0] ps_q [3];
	logic signed [27:0] m_q [3][3];
	logic signed [27:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [49:0] prod_w, p_q;
	logic signed [27:0] qq_w;
	logic signed [63:0] p_ext;
	logic signed [63:0] acc_q;
	logic [1:0]         row_q, col_q;
	logic               half_q;
	logic signed [CW-1:0] out_q [3];
	logic signed [48:0] row_sum_w;
	logic signed [CW-1:0] row_sat_w;

	// Output register.
	logic         m_tvalid_q;
	logic [111:0] m_tdata_q;
	logic         m_tuser_q;
	logic         out_free;

	assign cmd_w      = s_tuser;
	assign bead_idx_w = s_tdata[8:0];
	assign cx_w       = s_tdata[40:9];
	assign cy_w       = s_tdata[72:41];
	assign cz_w       = s_tdata[104:73];
	assign which_w    = s_tdata[105];
	assign ra_w       = $signed(s_tdata[123:106]);
	assign rb_w       = $signed(s_tdata[141:124]);
	assign ang_w      = $signed(s_tdata[160:142]);

	assign cfg_ready = 1'b1;
	assign s_tready  = (st_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Chain length is clamped to [2, MAX_BEADS]; the last bead is n-1 and its
	// neighbor n-2, the first bead is 0 and its neighbor 1.
	always_comb begin
		len_ext = NW'(chain_len_q);
		if (len_ext < NW'(2)) begin
			n_w = NW'(2);
		end else if (len_ext > NW'(MAX_BEADS)) begin
			n_w = NW'(MAX_BEADS);
		end else begin
			n_w = len_ext;
		end
		if (which_w) begin
			e_addr_w  = AW'(n_w - NW'(1));
			nb_addr_w = AW'(n_w - NW'(2));
		end else begin
			e_addr_w  = '0;
			nb_addr_w = AW'(1);
		end
	end

	// Angles beyond half pi are moved by pi and the CORDIC outputs negated.
	always_comb begin
		ang_ext = 20'(ang_w);
		ang_neg = 1'b0;
		ang_red = ang_ext;
		if (ang_ext > 20'sd102944) begin
			ang_red = ang_ext - 20'(cebr_pkg::PI_Q16);
			ang_neg = 1'b1;
		end else if (ang_ext < -20'sd102944) begin
			ang_red = ang_ext + 20'(cebr_pkg::PI_Q16);
			ang_neg = 1'b1;
		end
	end

	assign cp_w  = cor_neg_q ? -cor_x_q : cor_x_q;
	assign sp_w  = cor_neg_q ? -cor_y_q : cor_y_q;
	assign omc_w = 21'(cebr_pkg::ONE_Q16) - 21'(cp_w);

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op_q)
			OP_AA: begin mul_a = 28'(a_q); mul_b = 22'(a_q); end
			OP_BB: begin mul_a = 28'(b_q); mul_b = 22'(b_q); end
			OP_AR: begin mul_a = 28'(a_q); mul_b = $signed({5'd0, res_q[16:0]}); end
			OP_BR: begin mul_a = 28'(b_q); mul_b = $signed({5'd0, res_q[16:0]}); end
			OP_PXPX: begin mul_a = 28'(px_q); mul_b = 22'(px_q); end
			OP_PXPY: begin mul_a = 28'(px_q); mul_b = 22'(py_q); end
			OP_PXPZ: begin mul_a = 28'(px_q); mul_b = pz_q; end
			OP_PYPY: begin mul_a = 28'(py_q); mul_b = 22'(py_q); end
			OP_PYPZ: begin mul_a = 28'(py_q); mul_b = pz_q; end
			OP_PZPZ: begin mul_a = 28'(pz_q); mul_b = pz_q; end
			OP_PZSP: begin mul_a = 28'(pz_q); mul_b = 22'(sp_w); end
			OP_PYSP: begin mul_a = 28'(py_q); mul_b = 22'(sp_w); end
			OP_PXSP: begin mul_a = 28'(px_q); mul_b = 22'(sp_w); end
			OP_Q0: begin mul_a = 28'(pp_q[0]); mul_b = 22'(omc_w); end
			OP_Q1: begin mul_a = 28'(pp_q[1]); mul_b = 22'(omc_w); end
			OP_Q2: begin mul_a = 28'(pp_q[2]); mul_b = 22'(omc_w); end
			OP_Q3: begin mul_a = 28'(pp_q[3]); mul_b = 22'(omc_w); end
			OP_Q4: begin mul_a = 28'(pp_q[4]); mul_b = 22'(omc_w); end
			OP_Q5: begin mul_a = 28'(pp_q[5]); mul_b = 22'(omc_w); end
			OP_MB: begin
				mul_a = m_q[row_q][col_q];
				// The bond is split into a signed high half and an unsigned
				// low half so the product stays within the multiplier.
				if (half_q) begin
					mul_b = $signed({6'd0, bond_q[col_q][15:0]});
				end else begin
					mul_b = 22'($signed(bond_q[col_q][32:16]));
				end
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod_w = mul_a * mul_b;
	assign qq_w   = $signed(p_q[43:16]);
	assign p_ext  = 64'(p_q);
	assign trial_w = res_q + bit_q;

	// Row result: neighbor plus rotated bond, saturated to 32 bits.
	always_comb begin
		row_sum_w = 49'(nb_q[row_q]) + 49'(acc_q >>> 16);
		if (row_sum_w > 49'sh0_7FFF_FFFF) begin
			row_sat_w = 32'sh7FFF_FFFF;
		end else if (row_sum_w < -49'sh0_8000_0000) begin
			row_sat_w = -32'sh8000_0000;
		end else begin
			row_sat_w = row_sum_w[31:0];
		end
	end

	// Bead store ports: writes come from write requests and from the final
	// store of a rotation; reads go to the end bead, then its neighbor.
	always_comb begin
		if (st_q == ST_STORE) begin
			ram_we    = out_free;
			ram_waddr = e_addr_q;
			ram_wdata = {out_q[2], out_q[1], out_q[0]};
		end else begin
			ram_we    = s_acc && (cmd_w == cebr_pkg::CMD_WRITE) &&
				(32'(bead_idx_w) < MAX_BEADS);
			ram_waddr = AW'(bead_idx_w);
			ram_wdata = {cz_w, cy_w, cx_w};
		end
		ram_raddr = (st_q == ST_RD_E) ? e_addr_q : nb_addr_q;
	end

	cebr_ram #(
		.WIDTH(3 * CW),
		.DEPTH(MAX_BEADS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			op_q        <= OP_AA;
			chain_len_q <= cebr_pkg::CHAIN_LEN_RESET;
			cor_run_q   <= 1'b0;
			cor_cnt_q   <= '0;
			m_tvalid_q  <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			half_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				chain_len_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			// The CORDIC runs beside the sequencer; it is done long before
			// the sine and cosine are first used.
			if (cor_run_q) begin
				if (cor_z_q >= 0) begin
					cor_x_q <= cor_x_q - (cor_y_q >>> cor_cnt_q);
					cor_y_q <= cor_y_q + (cor_x_q >>> cor_cnt_q);
					cor_z_q <= cor_z_q - 20'(cebr_pkg::atan_q16(cor_cnt_q));
				end else begin
					cor_x_q <= cor_x_q + (cor_y_q >>> cor_cnt_q);
					cor_y_q <= cor_y_q - (cor_x_q >>> cor_cnt_q);
					cor_z_q <= cor_z_q + 20'(cebr_pkg::atan_q16(cor_cnt_q));
				end
				cor_cnt_q <= cor_cnt_q + 4'd1;
				if (cor_cnt_q == 4'(cebr_pkg::CORDIC_STEPS - 1)) begin
					cor_run_q <= 1'b0;
				end
			end

			case (st_q)
				ST_IDLE: begin
					if (s_acc && (cmd_w == cebr_pkg::CMD_ROTATE)) begin
						a_q       <= ra_w;
						b_q       <= rb_w;
						e_addr_q  <= e_addr_w;
						nb_addr_q <= nb_addr_w;
						cor_x_q   <= 20'(cebr_pkg::CORDIC_X0);
						cor_y_q   <= '0;
						cor_z_q   <= ang_red;
						cor_neg_q <= ang_neg;
						cor_cnt_q <= '0;
						cor_run_q <= 1'b1;
						op_q      <= OP_AA;
						row_q     <= '0;
						col_q     <= '0;
						half_q    <= 1'b0;
						acc_q     <= '0;
						st_q      <= ST_RD_E;
					end
				end
				ST_RD_E: begin
					st_q <= ST_RD_NB;
				end
				ST_RD_NB: begin
					e_pos_q[0] <= ram_rdata[CW-1:0];
					e_pos_q[1] <= ram_rdata[2*CW-1:CW];
					e_pos_q[2] <= ram_rdata[3*CW-1:2*CW];
					st_q <= ST_CAP_NB;
				end
				ST_CAP_NB: begin
					for (int c = 0; c < 3; c++) begin
						nb_q[c]   <= ram_rdata[c*CW +: CW];
						bond_q[c] <= 33'(e_pos_q[c]) -
							33'($signed(ram_rdata[c*CW +: CW]));
					end
					st_q <= ST_MUL;
				end
				ST_MUL: begin
					p_q  <= prod_w;
					st_q <= ST_WB;
				end
				ST_WB: begin
					st_q <= ST_MUL;
					op_q <= op_t'(op_q + 5'd1);
					case (op_q)
						OP_AA: s2_q <= p_q[35:0];
						OP_BB: begin
							s2_q <= s2_q + p_q[35:0];
							st_q <= ST_SQINIT;
						end
						OP_AR: px_q <= p_q[34:15];
						OP_BR: py_q <= p_q[34:15];
						OP_PXPX: pp_q[0] <= p_q[41:16];
						OP_PXPY: pp_q[1] <= p_q[41:16];
						OP_PXPZ: pp_q[2] <= p_q[41:16];
						OP_PYPY: pp_q[3] <= p_q[41:16];
						OP_PYPZ: pp_q[4] <= p_q[41:16];
						OP_PZPZ: pp_q[5] <= p_q[41:16];
						OP_PZSP: ps_q[0] <= p_q[37:16];
						OP_PYSP: ps_q[1] <= p_q[37:16];
						OP_PXSP: ps_q[2] <= p_q[37:16];
						// Diagonal entries add the cosine; off-diagonal pairs
						// share one product and differ in the sine term.
						OP_Q0: m_q[0][0] <= 28'(cp_w) + qq_w;
						OP_Q1: begin
							m_q[0][1] <= qq_w - 28'(ps_q[0]);
							m_q[1][0] <= qq_w + 28'(ps_q[0]);
						end
						OP_Q2: begin
							m_q[0][2] <= qq_w + 28'(ps_q[1]);
							m_q[2][0] <= qq_w - 28'(ps_q[1]);
						end
						OP_Q3: m_q[1][1] <= 28'(cp_w) + qq_w;
						OP_Q4: begin
							m_q[1][2] <= qq_w - 28'(ps_q[2]);
							m_q[2][1] <= qq_w + 28'(ps_q[2]);
						end
						OP_Q5: m_q[2][2] <= 28'(cp_w) + qq_w;
						OP_MB: begin
							op_q <= OP_MB;
							if (half_q) begin
								acc_q <= acc_q + p_ext;
							end else begin
								acc_q <= acc_q + (p_ext <<< 16);
							end
							half_q <= !half_q;
							if (half_q) begin
								if (col_q == 2'd2) begin
									col_q <= '0;
									st_q  <= ST_ROW;
								end else begin
									col_q <= col_q + 2'd1;
								end
							end
						end
						default: st_q <= ST_IDLE;
					endcase
				end
				ST_SQINIT: begin
					// A pair outside the unit disc clamps the root argument.
					clamp_q <= (s2_q > 36'h1_0000_0000);
					rem_q   <= (s2_q > 36'h1_0000_0000) ? '0 :
						34'(36'h1_0000_0000 - s2_q);
					res_q   <= '0;
					bit_q   <= 34'h1_0000_0000;
					pz_q    <= 22'(cebr_pkg::ONE_Q16) - $signed({1'b0, s2_q[35:15]});
					st_q    <= ST_SQRT;
				end
				ST_SQRT: begin
					if (rem_q >= trial_w) begin
						rem_q <= rem_q - trial_w;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						st_q <= ST_MUL;
					end
				end
				ST_ROW: begin
					out_q[row_q] <= row_sat_w;
					acc_q <= '0;
					if (row_q == 2'd2) begin
						st_q <= ST_STORE;
					end else begin
						row_q <= row_q + 2'd1;
						st_q  <= ST_MUL;
					end
				end
				ST_STORE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {7'd0, out_q[2], out_q[1], out_q[0],
							9'(e_addr_q)};
						m_tuser_q  <= clamp_q;
						st_q       <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// The CORDIC must be finished before the block takes a new request.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cor_run_q)
		else $error("cordic still running at idle");

	// The square root never exceeds one in Q16.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MUL && op_q == OP_AR) |-> (res_q <= 34'd65536))
		else $error("square root out of range");

	// Leaving the store state always presents a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_STORE && out_free) |=> m_tvalid_q)
		else $error("result lost at store");

	// A rotate request cannot yield a result in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && cmd_w == cebr_pkg::CMD_ROTATE) |=> !$rose(m_tvalid_q))
		else $error("result too early");

endmodule

@@ tb/sv/chain_end_bond_rotation_tb.sv @@
// Self-checking testbench for chain_end_bond_rotation: random bead writes and
// end rotations over several chain lengths, checked against a local predictor.
// Depends on cebr_pkg and the chain_end_bond_rotation RTL.
module chain_end_bond_rotation_tb;

	localparam int MAX_BEADS = cebr_pkg::MAX_BEADS;
	localparam int IDX_W = cebr_pkg::IDX_W;
	localparam int COORD_W = cebr_pkg::COORD_W;
	localparam int RAND_W = cebr_pkg::RAND_W;
	localparam int ANGLE_W = cebr_pkg::ANGLE_W;
	localparam int ONE_Q16 = cebr_pkg::ONE_Q16;
	localparam int CORDIC_X0 = cebr_pkg::CORDIC_X0;
	localparam int PI_Q16 = cebr_pkg::PI_Q16;
	localparam int HALF_PI_Q16 = cebr_pkg::HALF_PI_Q16;
	localparam logic [9:0] CHAIN_LEN_RESET = cebr_pkg::CHAIN_LEN_RESET;

	typedef enum logic {END_FIRST = 1'b0, END_LAST = 1'b1} end_e;

	typedef struct {
		cebr_pkg::cmd_t cmd;
		logic [IDX_W-1:0] idx;
		logic signed [COORD_W-1:0] x, y, z;
		end_e which;
		logic signed [RAND_W-1:0] ra, rb;
		logic signed [ANGLE_W-1:0] ang;
	} request_t;

	typedef struct {
		logic [IDX_W-1:0] idx;
		logic signed [COORD_W-1:0] x, y, z;
		logic clamped;
	} move_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [9:0] cfg_data = '0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [167:0] s_tdata = '0;  // bead_index, coord_x, coord_y, coord_z, which_end,
	                             // rand_a, rand_b, angle, zero padding
	logic s_tuser = 0;           // command
	logic m_tvalid;
	logic m_tready = 0;
	logic [111:0] m_tdata;       // end_index, new_x, new_y, new_z, padding
	logic m_tuser;               // root_clamped

	chain_end_bond_rotation dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Requests still to be sent and bead moves still to be reported.
	request_t pending_requests[$];
	move_t expected_moves[$];
	request_t cur_request;

	// Predictor state: its own copy of the bead store and the chain length.
	int signed bead_pos[MAX_BEADS][3];
	logic [9:0] chain_len_reg = CHAIN_LEN_RESET;
	// Generator bookkeeping so that no unwritten bead is ever read.
	bit bead_written[MAX_BEADS];

	int errors = 0;
	int rotations = 0;
	int clamps = 0;
	bit no_idle = 0;
	int send_gap = 0;
	int recv_gap = 0;

	localparam longint ATAN_Q16[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint q16_mul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic int signed sat32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return int'(v);
	endfunction

	// Applies one accepted request to the predicted bead store and, for a
	// rotation, queues the bead move that the block has to report.
	task automatic apply_request(request_t r);
		longint n, e, nb, a, b, s2, root, px, py, pz, cx, sy, zr, t, omc, acc;
		longint m[3][3];
		longint bond[3];
		bit flip, clamped;
		move_t mv;
		if (r.cmd == cebr_pkg::CMD_WRITE) begin
			bead_pos[r.idx][0] = r.x;
			bead_pos[r.idx][1] = r.y;
			bead_pos[r.idx][2] = r.z;
			return;
		end
		n = chain_len_reg;
		if (n < 2) n = 2;
		if (n > MAX_BEADS) n = MAX_BEADS;
		if (r.which == END_LAST) begin
			e = n - 1;
			nb = n - 2;
		end else begin
			e = 0;
			nb = 1;
		end
		a = r.ra;
		b = r.rb;
		s2 = a * a + b * b;
		clamped = s2 > 64'sd4294967296;
		root = clamped ? 0 : longint'(floor_sqrt(64'd4294967296 - s2));
		px = (2 * a * root) >>> 16;
		py = (2 * b * root) >>> 16;
		pz = ONE_Q16 - (s2 >>> 15);

		// CORDIC in rotation mode; angles past a quarter turn are folded by pi.
		cx = CORDIC_X0;
		sy = 0;
		zr = r.ang;
		flip = 0;
		if (zr > HALF_PI_Q16) begin
			zr -= PI_Q16;
			flip = 1;
		end else if (zr < -HALF_PI_Q16) begin
			zr += PI_Q16;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (zr >= 0) begin
				t = cx - (sy >>> i);
				sy = sy + (cx >>> i);
				zr -= ATAN_Q16[i];
			end else begin
				t = cx + (sy >>> i);
				sy = sy - (cx >>> i);
				zr += ATAN_Q16[i];
			end
			cx = t;
		end
		if (flip) begin
			cx = -cx;
			sy = -sy;
		end
		omc = ONE_Q16 - cx;

		m[0][0] = cx + q16_mul(q16_mul(px, px), omc);
		m[0][1] = q16_mul(q16_mul(px, py), omc) - q16_mul(pz, sy);
		m[0][2] = q16_mul(q16_mul(px, pz), omc) + q16_mul(py, sy);
		m[1][0] = q16_mul(q16_mul(px, py), omc) + q16_mul(pz, sy);
		m[1][1] = cx + q16_mul(q16_mul(py, py), omc);
		m[1][2] = q16_mul(q16_mul(py, pz), omc) - q16_mul(px, sy);
		m[2][0] = q16_mul(q16_mul(px, pz), omc) - q16_mul(py, sy);
		m[2][1] = q16_mul(q16_mul(py, pz), omc) + q16_mul(px, sy);
		m[2][2] = cx + q16_mul(q16_mul(pz, pz), omc);

		for (int c = 0; c < 3; c++)
			bond[c] = longint'(bead_pos[e][c]) - longint'(bead_pos[nb][c]);
		mv.idx = e[IDX_W-1:0];
		mv.clamped = clamped;
		for (int c = 0; c < 3; c++) begin
			acc = 0;
			for (int i = 0; i < 3; i++)
				acc += m[c][i] * bond[i];
			bead_pos[e][c] = sat32(longint'(bead_pos[nb][c]) + (acc >>> 16));
		end
		mv.x = bead_pos[e][0];
		mv.y = bead_pos[e][1];
		mv.z = bead_pos[e][2];
		expected_moves.push_back(mv);
		rotations++;
		if (clamped) clamps++;
	endtask

	function automatic logic [167:0] pack_request(request_t r);
		return {7'd0, r.ang, r.rb, r.ra, r.which, r.z, r.y, r.x, r.idx};
	endfunction

	// Driver: a new request goes out once the current one has been taken.
	// Random gaps come in bursts unless idling is off.
	always @(posedge clk) begin
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (s_tvalid)
				apply_request(cur_request);
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 0;
			end else if (pending_requests.size() > 0) begin
				cur_request = pending_requests.pop_front();
				s_tdata <= pack_request(cur_request);
				s_tuser <= cur_request.cmd;
				s_tvalid <= 1;
				if (!no_idle && $urandom_range(0, 7) == 0)
					send_gap = $urandom_range(1, 12);
			end else begin
				s_tvalid <= 0;
			end
		end
	end

	// Monitor: each reported move is checked against the oldest expected one.
	// The ready side stalls in random bursts too.
	always @(posedge clk) begin
		move_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_moves.size() == 0) begin
					report_mismatch("unexpected result, end_index", m_tdata[8:0], -1);
				end else begin
					want = expected_moves.pop_front();
					if (m_tdata[8:0] !== want.idx)
						report_mismatch("end_index", m_tdata[8:0], want.idx);
					if ($signed(m_tdata[40:9]) !== want.x)
						report_mismatch("new_x", $signed(m_tdata[40:9]), want.x);
					if ($signed(m_tdata[72:41]) !== want.y)
						report_mismatch("new_y", $signed(m_tdata[72:41]), want.y);
					if ($signed(m_tdata[104:73]) !== want.z)
						report_mismatch("new_z", $signed(m_tdata[104:73]), want.z);
					if (m_tuser !== want.clamped)
						report_mismatch("root_clamped", m_tuser, want.clamped);
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 11);
				m_tready <= 0;
			end else begin
				m_tready <= 1;
			end
		end
	end

	function automatic request_t write_request(int idx, int signed x, int signed y,
			int signed z);
		request_t r;
		r = '{cmd: cebr_pkg::CMD_WRITE, idx: IDX_W'(idx), x: x, y: y, z: z,
			which: END_FIRST, ra: RAND_W'($urandom), rb: RAND_W'($urandom),
			ang: ANGLE_W'($urandom)};
		bead_written[idx] = 1;
		return r;
	endfunction

	function automatic request_t rotate_request(end_e which, int ra, int rb, int ang);
		request_t r;
		r = '{cmd: cebr_pkg::CMD_ROTATE, idx: IDX_W'($urandom), x: $urandom,
			y: $urandom, z: $urandom, which: which, ra: RAND_W'(ra),
			rb: RAND_W'(rb), ang: ANGLE_W'(ang)};
		return r;
	endfunction

	function automatic int signed random_coord();
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
	endfunction

	// Fills the request queue for one chain length. Rotations only go out
	// once both beads they read have been written.
	task automatic queue_random(int count, int len);
		int n, e, nb, idx, ra, rb, ang;
		end_e which;
		n = (len < 2) ? 2 : (len > MAX_BEADS) ? MAX_BEADS : len;
		for (int k = 0; k < count; k++) begin
			which = end_e'($urandom_range(0, 1));
			e = (which == END_LAST) ? n - 1 : 0;
			nb = (which == END_LAST) ? n - 2 : 1;
			if (bead_written[e] && bead_written[nb] && $urandom_range(0, 9) < 6) begin
				if ($urandom_range(0, 2) == 0) begin
					ra = $signed($urandom_range(0, 262143)) - 131072;
					rb = $signed($urandom_range(0, 262143)) - 131072;
				end else begin
					ra = $signed($urandom_range(0, 92000)) - 46000;
					rb = $signed($urandom_range(0, 92000)) - 46000;
				end
				if ($urandom_range(0, 4) == 0)
					ang = $signed($urandom_range(0, 524287)) - 262144;
				else
					ang = $signed($urandom_range(0, 2 * PI_Q16)) - PI_Q16;
				pending_requests.push_back(rotate_request(which, ra, rb, ang));
			end else begin
				case ($urandom_range(0, 4))
					0: idx = 0;
					1: idx = 1;
					2: idx = n - 2;
					3: idx = n - 1;
					default: idx = $urandom_range(0, MAX_BEADS - 1);
				endcase
				pending_requests.push_back(write_request(idx, random_coord(),
					random_coord(), random_coord()));
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() > 0 || s_tvalid || expected_moves.size() > 0)
			@(posedge clk);
		// Writes leave no result, so allow the block to finish whatever it holds.
		repeat (110) @(posedge clk);
	endtask

	task automatic write_chain_len(logic [9:0] v);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		chain_len_reg = v;
	endtask

	initial begin
		int lens[$];
		repeat (6) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed: coordinate extremes, rand pairs on and off the unit disc,
		// angles at zero, plus and minus pi, and the ends of the angle field.
		pending_requests.push_back(write_request(0, 32'sh7fffffff, 32'sh80000000, 0));
		pending_requests.push_back(write_request(1, 32'sh80000000, 32'sh7fffffff, -1));
		pending_requests.push_back(write_request(511, -1, -1, -1));
		pending_requests.push_back(rotate_request(END_FIRST, 0, 0, 0));
		pending_requests.push_back(rotate_request(END_LAST, 131071, -131072, PI_Q16));
		pending_requests.push_back(write_request(0, 65536, 0, 0));
		pending_requests.push_back(write_request(1, 0, 0, 0));
		pending_requests.push_back(rotate_request(END_FIRST, 0, 0, HALF_PI_Q16));
		pending_requests.push_back(rotate_request(END_FIRST, 30000, -20000, -PI_Q16));
		pending_requests.push_back(rotate_request(END_LAST, -131072, -131072, 262143));
		pending_requests.push_back(rotate_request(END_FIRST, 65536, 0, -262144));
		pending_requests.push_back(rotate_request(END_LAST, 0, 65536, HALF_PI_Q16 + 1));
		pending_requests.push_back(rotate_request(END_FIRST, 46341, 46341, 12345));
		wait_drained();

		// Chain lengths: both out-of-range sides, the extremes, then random ones.
		lens = '{1023, 0, 1, 512, 513, 3};
		repeat (4) lens.push_back($urandom_range(2, 512));
		lens.push_back(2);
		foreach (lens[i]) begin
			write_chain_len(10'(lens[i]));
			if (i == lens.size() - 1)
				no_idle = 1;
			queue_random(80, lens[i]);
			wait_drained();
		end

		$display("Covered %0d bead rotations (%0d with the root clamped) over %0d chain lengths.",
			rotations, clamps, lens.size() + 1);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#16000000;
		$display("Timed out with %0d results outstanding.", expected_moves.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule
